>>> rtl/core/ds2i64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ds2i64_pkg - shared definitions for the decimal string to int64 unit
// Character codes, limits, widths and result status codes.
// ----------------------------------------------------------------------------
package ds2i64_pkg;

	// Default string length limit; characters at or beyond it are ignored
	localparam int MAX_LEN_DEF = 65535;

	// Field widths
	localparam int CHAR_W  = 8;
	localparam int VALUE_W = 64;
	localparam int STAT_W  = 2;
	localparam int OFFS_W  = 16;
	localparam int SIG_W   = 5;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	// Limits
	localparam logic [SIG_W-1:0]   SIG_MAX   = 5'd20;
	localparam logic [VALUE_W-1:0] MUL_LIMIT = 64'd1844674407370955161;
	localparam logic [VALUE_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
	localparam logic [VALUE_W-1:0] POS_SAT   = 64'hffff_ffff_ffff_ffff;

	// Result status; ST_OK_POS also marks "nothing special yet" in the outcome register
	typedef enum logic [STAT_W-1:0] {
		ST_OK_POS = 2'd0,
		ST_OK_NEG = 2'd1,
		ST_RANGE  = 2'd2,
		ST_NODIG  = 2'd3
	} status_t;

endpackage

>>> rtl/core/decimal_string_to_int64_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_string_to_int64_unit - streaming decimal string to int64 converter
// Parses one character per transaction: blanks, optional sign, leading zeros,
// up to 20 significant digits. The final character of a string yields value,
// status and stop offset.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------
//  input   | in_valid, in_stall | char_code, frame_last, empty_frame
//  output  | out_valid,out_stall| value, status, stop_offset
//
//  One character per cycle while in_stall is low; the parse state advances
//  in the cycle it is taken. A result passes through the finish register,
//  then the output register with the negate and range check.
//  in_stall rises only when both the finish and output registers hold
//  results and the output side stalls.
//  arst_n clears the parse state and both valid flags.
//
module decimal_string_to_int64_unit #(
	parameter int MAX_LEN = ds2i64_pkg::MAX_LEN_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [ds2i64_pkg::CHAR_W-1:0]        char_code,
	input  logic                                 frame_last,
	input  logic                                 empty_frame,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [ds2i64_pkg::VALUE_W-1:0] value,
	output logic [ds2i64_pkg::STAT_W-1:0]        status,
	output logic [ds2i64_pkg::OFFS_W-1:0]        stop_offset
);

	localparam int POS_W = $clog2(MAX_LEN + 1);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);

	typedef enum logic [2:0] {
		PH_BLANK,
		PH_SIGNED,
		PH_ZEROS,
		PH_DIGITS,
		PH_STOPPED
	} phase_t;

	// Parse state
	phase_t                          phase_q;
	logic                            neg_q;
	logic [ds2i64_pkg::VALUE_W-1:0]  acc_q;
	logic [ds2i64_pkg::SIG_W-1:0]    sig_q;
	logic [POS_W-1:0]                pos_q;
	logic [POS_W-1:0]                stop_q;
	ds2i64_pkg::status_t             outc_q;

	phase_t                          phase_n;
	logic                            neg_n;
	logic [ds2i64_pkg::VALUE_W-1:0]  acc_n;
	logic [ds2i64_pkg::SIG_W-1:0]    sig_n;
	logic [POS_W-1:0]                pos_n;
	logic [POS_W-1:0]                stop_n;
	ds2i64_pkg::status_t             outc_n;

	// Finish stage
	logic                            valid_s1;
	logic [ds2i64_pkg::VALUE_W-1:0]  acc_s1;
	logic                            neg_s1;
	logic                            nodig_s1;
	logic                            range_s1;
	logic [POS_W-1:0]                stop_s1;

	// Output stage
	logic                            valid_s2;
	logic [ds2i64_pkg::VALUE_W-1:0]  value_s2;
	ds2i64_pkg::status_t             status_s2;
	logic [POS_W-1:0]                stop_s2;

	logic                            in_acc;
	logic                            adv_s2;
	logic                            take;
	logic                            first;
	logic                            dig;
	logic [3:0]                      dval;
	logic [ds2i64_pkg::VALUE_W-1:0]  acc_mul;
	logic                            ovf;

	// Handshake
	assign adv_s2   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign in_acc   = in_valid && !in_stall;

	// Digit decode and multiply-accumulate
	assign dig     = char_code inside {[ds2i64_pkg::CH_ZERO:ds2i64_pkg::CH_NINE]};
	assign dval    = dig ? char_code[3:0] : 4'd0;
	assign acc_mul = (acc_q << 3) + (acc_q << 1)
		+ {{(ds2i64_pkg::VALUE_W-4){1'b0}}, dval};
	assign ovf     = (acc_q > ds2i64_pkg::MUL_LIMIT)
		|| ((acc_q == ds2i64_pkg::MUL_LIMIT) && (dval > 4'd5));
	assign take    = !empty_frame && (pos_q < POS_LIMIT);

	// Next parse state for one character
	always_comb begin
		phase_n = phase_q;
		neg_n   = neg_q;
		acc_n   = acc_q;
		sig_n   = sig_q;
		pos_n   = pos_q;
		stop_n  = stop_q;
		outc_n  = outc_q;
		first   = 1'b0;
		if (take) begin
			pos_n = pos_q + 1'b1;
			case (phase_q)
				PH_BLANK: begin
					if (char_code == ds2i64_pkg::CH_SPACE || char_code == ds2i64_pkg::CH_TAB) begin
						phase_n = PH_BLANK;
					end else if (char_code == ds2i64_pkg::CH_MINUS) begin
						neg_n   = 1'b1;
						phase_n = PH_SIGNED;
					end else if (char_code == ds2i64_pkg::CH_PLUS) begin
						phase_n = PH_SIGNED;
					end else begin
						first = 1'b1;
					end
				end
				PH_SIGNED: begin
					first = 1'b1;
				end
				PH_ZEROS: begin
					if (char_code == ds2i64_pkg::CH_ZERO) begin
						stop_n = pos_q + 1'b1;
					end else if (dig) begin
						acc_n   = {{(ds2i64_pkg::VALUE_W-4){1'b0}}, dval};
						sig_n   = ds2i64_pkg::SIG_W'(1);
						phase_n = PH_DIGITS;
						stop_n  = pos_q + 1'b1;
					end else begin
						phase_n = PH_STOPPED;
					end
				end
				PH_DIGITS: begin
					if (!dig) begin
						phase_n = PH_STOPPED;
					end else if (sig_q >= ds2i64_pkg::SIG_MAX) begin
						// 21st significant digit
						outc_n  = ds2i64_pkg::ST_RANGE;
						phase_n = PH_STOPPED;
					end else if (ovf) begin
						stop_n  = pos_q + 1'b1;
						outc_n  = ds2i64_pkg::ST_RANGE;
						phase_n = PH_STOPPED;
					end else begin
						acc_n  = acc_mul;
						sig_n  = sig_q + 1'b1;
						stop_n = pos_q + 1'b1;
					end
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
			// First character after blanks and sign
			if (first) begin
				if (char_code == ds2i64_pkg::CH_ZERO) begin
					phase_n = PH_ZEROS;
					stop_n  = pos_q + 1'b1;
				end else if (dig) begin
					acc_n   = {{(ds2i64_pkg::VALUE_W-4){1'b0}}, dval};
					sig_n   = ds2i64_pkg::SIG_W'(1);
					phase_n = PH_DIGITS;
					stop_n  = pos_q + 1'b1;
				end else begin
					outc_n  = ds2i64_pkg::ST_NODIG;
					stop_n  = '0;
					phase_n = PH_STOPPED;
				end
			end
		end
	end

	// Parse state registers; cleared after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BLANK;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			sig_q   <= '0;
			pos_q   <= '0;
			stop_q  <= '0;
			outc_q  <= ds2i64_pkg::ST_OK_POS;
		end else if (in_acc) begin
			if (frame_last) begin
				phase_q <= PH_BLANK;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				sig_q   <= '0;
				pos_q   <= '0;
				stop_q  <= '0;
				outc_q  <= ds2i64_pkg::ST_OK_POS;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				sig_q   <= sig_n;
				pos_q   <= pos_n;
				stop_q  <= stop_n;
				outc_q  <= outc_n;
			end
		end
	end

	// Finish stage: snapshot of the final parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_s2) begin
			valid_s1 <= in_acc && frame_last;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && frame_last) begin
			acc_s1   <= acc_n;
			neg_s1   <= neg_n;
			nodig_s1 <= (phase_n == PH_BLANK) || (phase_n == PH_SIGNED)
				|| (outc_n == ds2i64_pkg::ST_NODIG);
			range_s1 <= (outc_n == ds2i64_pkg::ST_RANGE);
			stop_s1  <= stop_n;
		end
	end

	// Output stage: range check, saturation and negate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			if (nodig_s1) begin
				status_s2 <= ds2i64_pkg::ST_NODIG;
				value_s2  <= '0;
				stop_s2   <= '0;
			end else if (range_s1 || (neg_s1 && (acc_s1 > ds2i64_pkg::NEG_LIMIT))) begin
				status_s2 <= ds2i64_pkg::ST_RANGE;
				value_s2  <= neg_s1 ? ds2i64_pkg::NEG_LIMIT : ds2i64_pkg::POS_SAT;
				stop_s2   <= stop_s1;
			end else if (neg_s1) begin
				status_s2 <= ds2i64_pkg::ST_OK_NEG;
				value_s2  <= '0 - acc_s1;
				stop_s2   <= stop_s1;
			end else begin
				status_s2 <= ds2i64_pkg::ST_OK_POS;
				value_s2  <= acc_s1;
				stop_s2   <= stop_s1;
			end
		end
	end

	assign out_valid   = valid_s2;
	assign value       = value_s2;
	assign status      = status_s2;
	assign stop_offset = ds2i64_pkg::OFFS_W'(stop_s2);

endmodule

>>> rtl/core/ds2i64_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ds2i64_checker - port-level checks for the decimal string to int64 unit
// Watches result transactions for consistent value, status and offset.
// ----------------------------------------------------------------------------
module ds2i64_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic signed [ds2i64_pkg::VALUE_W-1:0] value,
	input logic [ds2i64_pkg::STAT_W-1:0]         status,
	input logic [ds2i64_pkg::OFFS_W-1:0]         stop_offset
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(status)
			&& $stable(stop_offset))
		else $error("stalled result changed");

	// No digits: zero value and zero offset
	a_nodig: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ds2i64_pkg::ST_NODIG |-> value == '0 && stop_offset == '0)
		else $error("no-digit result not cleared");

	// Out of range saturates to one of two patterns
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ds2i64_pkg::ST_RANGE |->
			value == ds2i64_pkg::POS_SAT || value == ds2i64_pkg::NEG_LIMIT)
		else $error("out of range value not saturated");

	// Negative result is negative or zero
	a_neg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ds2i64_pkg::ST_OK_NEG |-> value[63] || value == '0)
		else $error("negative result has wrong sign");

	// A parsed value consumed at least one character
	a_offs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ds2i64_pkg::ST_OK_POS |-> stop_offset != '0)
		else $error("ok result with zero stop offset");

endmodule

bind decimal_string_to_int64_unit ds2i64_checker u_ds2i64_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.value       (value),
	.status      (status),
	.stop_offset (stop_offset)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - decimal string to int64 unit
// Streams strings into the converter one character per transaction and checks
// every value, status and stop offset against a behavioral parser kept in this
// bench. Covers blanks, signs, leading zeros, range limits, empty items,
// output hold-off and random traffic on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import ds2i64_pkg::*;

	localparam int MAX_LEN      = MAX_LEN_DEF;
	localparam int RANDOM_ITEMS = 1050;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_TAIL   = 8;
	localparam int PRINT_CAP    = 40;

	typedef enum logic [2:0] {
		SCAN_BLANK,
		SCAN_SIGNED,
		SCAN_ZEROS,
		SCAN_DIGITS,
		SCAN_STOPPED
	} scan_phase_t;

	typedef struct {
		logic [VALUE_W-1:0] value;
		status_t            code;
		logic [OFFS_W-1:0]  offset;
	} conversion_t;

	typedef logic [CHAR_W-1:0] byte_q_t[$];

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       in_valid    = 1'b0;
	logic [CHAR_W-1:0]          char_code   = '0;
	logic                       frame_last  = 1'b0;
	logic                       empty_frame = 1'b0;
	logic                       out_stall   = 1'b0;
	logic                       in_stall;
	logic                       out_valid;
	logic signed [VALUE_W-1:0]  value;
	logic [STAT_W-1:0]          status;
	logic [OFFS_W-1:0]          stop_offset;

	// parser state of the bench copy
	scan_phase_t        scan_phase;
	logic               neg_sign;
	logic [VALUE_W-1:0] acc_value;
	logic [SIG_W-1:0]   digit_cnt;
	int                 char_pos;
	logic [OFFS_W-1:0]  stop_pos;
	status_t            scan_verdict;

	conversion_t expected_conversions[$];
	int          mismatch_count = 0;
	int          items_sent     = 0;
	int          cycle_count    = 0;
	bit          send_quiet     = 1'b0;
	bit          recv_quiet     = 1'b0;
	int          hold_request   = 0;

	decimal_string_to_int64_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_code   (char_code),
		.frame_last  (frame_last),
		.empty_frame (empty_frame),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value),
		.status      (status),
		.stop_offset (stop_offset)
	);

	always #2 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("decimal_string_to_int64_unit: mismatch");
			$finish;
		end
	end

	task automatic log_mismatch(input string what, input logic [VALUE_W-1:0] got,
		input logic [VALUE_W-1:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// Bench parser
	// ------------------------------------------------------------------
	function automatic void clear_scan();
		scan_phase   = SCAN_BLANK;
		neg_sign     = 1'b0;
		acc_value    = '0;
		digit_cnt    = '0;
		char_pos     = 0;
		stop_pos     = '0;
		scan_verdict = ST_OK_POS;
	endfunction

	// first character after blanks and sign decides digits or nothing
	function automatic void take_first_char(input logic [CHAR_W-1:0] c, input int p);
		if (c == CH_ZERO) begin
			scan_phase = SCAN_ZEROS;
			stop_pos   = OFFS_W'(p + 1);
		end else if (c > CH_ZERO && c <= CH_NINE) begin
			acc_value  = VALUE_W'(c - CH_ZERO);
			digit_cnt  = SIG_W'(1);
			scan_phase = SCAN_DIGITS;
			stop_pos   = OFFS_W'(p + 1);
		end else begin
			scan_verdict = ST_NODIG;
			stop_pos     = '0;
			scan_phase   = SCAN_STOPPED;
		end
	endfunction

	function automatic void scan_char(input logic [CHAR_W-1:0] c, input int p);
		logic       is_digit;
		logic [3:0] d;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		d = is_digit ? 4'(c - CH_ZERO) : 4'd0;
		case (scan_phase)
		SCAN_BLANK: begin
			if (c == CH_MINUS) begin
				neg_sign   = 1'b1;
				scan_phase = SCAN_SIGNED;
			end else if (c == CH_PLUS)
				scan_phase = SCAN_SIGNED;
			else if (c != CH_SPACE && c != CH_TAB)
				take_first_char(c, p);
		end
		SCAN_SIGNED: take_first_char(c, p);
		SCAN_ZEROS: begin
			if (c == CH_ZERO)
				stop_pos = OFFS_W'(p + 1);
			else if (is_digit) begin
				acc_value  = VALUE_W'(d);
				digit_cnt  = SIG_W'(1);
				scan_phase = SCAN_DIGITS;
				stop_pos   = OFFS_W'(p + 1);
			end else
				scan_phase = SCAN_STOPPED;
		end
		SCAN_DIGITS: begin
			if (!is_digit)
				scan_phase = SCAN_STOPPED;
			else if (digit_cnt >= SIG_MAX) begin
				// 21st significant digit: not consumed
				scan_verdict = ST_RANGE;
				scan_phase   = SCAN_STOPPED;
			end else if (acc_value > MUL_LIMIT || (acc_value == MUL_LIMIT && d > 4'd5)) begin
				// overflowing digit counts as consumed
				stop_pos     = OFFS_W'(p + 1);
				scan_verdict = ST_RANGE;
				scan_phase   = SCAN_STOPPED;
			end else begin
				acc_value = acc_value * 64'd10 + VALUE_W'(d);
				digit_cnt = digit_cnt + 1'b1;
				stop_pos  = OFFS_W'(p + 1);
			end
		end
		default: ;
		endcase
	endfunction

	// one accepted transaction; a final item queues the expected conversion
	function automatic void predict_item(input logic [CHAR_W-1:0] c, input logic last,
		input logic empty);
		conversion_t r;
		if (!empty && char_pos < MAX_LEN) begin
			scan_char(c, char_pos);
			char_pos++;
		end
		if (!last)
			return;
		r.offset = stop_pos;
		if (scan_phase == SCAN_BLANK || scan_phase == SCAN_SIGNED || scan_verdict == ST_NODIG) begin
			r.code   = ST_NODIG;
			r.value  = '0;
			r.offset = '0;
		end else if (scan_verdict == ST_RANGE || (neg_sign && acc_value > NEG_LIMIT)) begin
			r.code  = ST_RANGE;
			r.value = neg_sign ? NEG_LIMIT : POS_SAT;
		end else if (neg_sign) begin
			r.code  = ST_OK_NEG;
			r.value = 64'd0 - acc_value;
		end else begin
			r.code  = ST_OK_POS;
			r.value = acc_value;
		end
		expected_conversions.push_back(r);
		clear_scan();
	endfunction

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		conversion_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_conversions.size() == 0)
				log_mismatch("result with none pending", value, '0);
			else begin
				want = expected_conversions.pop_front();
				if (value !== want.value)
					log_mismatch("value", value, want.value);
				if (status !== want.code)
					log_mismatch("status", VALUE_W'(status), VALUE_W'(want.code));
				if (stop_offset !== want.offset)
					log_mismatch("stop_offset", VALUE_W'(stop_offset), VALUE_W'(want.offset));
			end
		end
	end

	// ------------------------------------------------------------------
	// Output side: random stall per result, long hold-off on request
	// ------------------------------------------------------------------
	initial begin : receiver
		int n;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request != 0)
				n = hold_request;
			else
				n = recv_quiet ? 0 : $urandom_range(0, 7);
			hold_request = 0;
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	task automatic send_char(input logic [CHAR_W-1:0] c, input logic last, input logic empty);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		char_code   <= c;
		frame_last  <= last;
		empty_frame <= empty;
		do @(posedge clk); while (in_stall);
		predict_item(c, last, empty);
		items_sent++;
	endtask

	// one string; optionally closed by an empty item, optionally with stray empty items
	task automatic send_frame(input byte_q_t chars, input bit close_empty, input bit sprinkle);
		for (int i = 0; i < chars.size(); i++) begin
			if (sprinkle && $urandom_range(0, 15) == 0)
				send_char(8'($urandom), 1'b0, 1'b1);
			send_char(chars[i], !close_empty && i == chars.size() - 1, 1'b0);
		end
		if (close_empty || chars.size() == 0)
			send_char(8'($urandom), 1'b1, 1'b1);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_conversions.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	function automatic byte_q_t text(input string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	function automatic logic [CHAR_W-1:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// no digits, signs alone, zeros, empty items, raw byte extremes
	task automatic test_special_forms();
		byte_q_t chars;
		send_frame(text(""), 1'b1, 1'b0);
		send_frame(text(" \t  "), 1'b0, 1'b0);
		send_frame(text("-"), 1'b0, 1'b0);
		send_frame(text("+"), 1'b1, 1'b0);
		send_frame(text("  x12"), 1'b0, 1'b0);
		send_frame(text("-x"), 1'b0, 1'b0);
		send_frame(text("-0"), 1'b0, 1'b0);
		send_frame(text("0"), 1'b0, 1'b0);
		send_frame(text("\t+0007k"), 1'b0, 1'b0);
		send_frame(text("00 5"), 1'b1, 1'b0);
		// empty item in mid-string is ignored
		send_char("4", 1'b0, 1'b0);
		send_char(8'hff, 1'b0, 1'b1);
		send_char("2", 1'b1, 1'b0);
		chars = text("12");
		chars.push_back(8'hff);
		send_frame(chars, 1'b0, 1'b0);
		chars.delete();
		chars.push_back(8'h00);
		send_frame(chars, 1'b0, 1'b0);
		drain_results();
	endtask

	// range limits on both signs and the digit count limit
	task automatic test_extremes();
		string cases[$] = '{
			"18446744073709551615",
			"18446744073709551616",
			"9223372036854775807",
			"-9223372036854775808",
			"-9223372036854775809",
			"-18446744073709551615",
			"99999999999999999999",
			"123456789012345678901",
			"12345678901234567890x",
			"  +00000000000000000000000000042"
		};
		foreach (cases[i])
			send_frame(text(cases[i]), i % 3 == 0, 1'b0);
		drain_results();
	endtask

	// output held off long enough for the unit to back up into its input
	task automatic test_output_hold();
		byte_q_t chars;
		send_quiet   = 1'b1;
		hold_request = 150;
		repeat (40) begin
			chars.delete();
			if ($urandom_range(0, 1))
				chars.push_back(CH_MINUS);
			chars.push_back(rand_digit());
			chars.push_back(rand_digit());
			send_frame(chars, 1'b0, 1'b0);
		end
		send_quiet = 1'b0;
		drain_results();
	endtask

	// mostly well-formed numbers with random content, some noise frames
	task automatic test_random_strings();
		byte_q_t chars;
		string   limit;
		int      start;
		int      n;
		int      k;
		int      pick;
		bit      paused;
		start  = items_sent;
		paused = 1'b0;
		while (items_sent - start < RANDOM_ITEMS) begin
			// halfway: sender waits for every pending result
			if (!paused && items_sent - start >= RANDOM_ITEMS / 2) begin
				drain_results();
				paused = 1'b1;
			end
			send_quiet = ($urandom_range(0, 7) == 0);
			recv_quiet = ($urandom_range(0, 7) == 0);
			chars.delete();
			if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(0, 6);
				repeat (n) chars.push_back(8'($urandom));
			end else begin
				n = $urandom_range(0, 2);
				repeat (n) chars.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
				pick  = $urandom_range(0, 3);
				limit = "18446744073709551615";
				if (pick == 1) begin
					chars.push_back(CH_MINUS);
					limit = "9223372036854775808";
				end else if (pick == 2)
					chars.push_back(CH_PLUS);
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
				repeat (n) chars.push_back(CH_ZERO);
				case ($urandom_range(0, 3))
				0: begin
					n = $urandom_range(1, 6);
					repeat (n) chars.push_back(rand_digit());
				end
				1: begin
					n = $urandom_range(15, 21);
					repeat (n) chars.push_back(rand_digit());
				end
				2: begin
					// near the range limit: one digit changed, or none
					k = $urandom_range(0, 1) ? $urandom_range(17, limit.len())
						: $urandom_range(0, limit.len());
					for (int i = 0; i < limit.len(); i++)
						chars.push_back(i == k ? rand_digit() : limit[i]);
					if ($urandom_range(0, 3) == 0)
						chars.push_back(rand_digit());
				end
				default: ;
				endcase
				n = $urandom_range(0, 2);
				repeat (n) chars.push_back(8'($urandom));
			end
			send_frame(chars, $urandom_range(0, 3) == 0, 1'b1);
		end
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
	endtask

	initial begin
		clear_scan();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_forms();
		test_extremes();
		test_output_hold();
		test_random_strings();
		drain_results();
		if (mismatch_count == 0)
			$display("decimal_string_to_int64_unit: match");
		else
			$display("decimal_string_to_int64_unit: mismatch");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/ds2i64_pkg.sv
rtl/core/decimal_string_to_int64_unit.sv
rtl/core/ds2i64_checker.sv
dv/testbench.sv
